[rtl/kps_pkg.sv]
// Shared types, codes and constants for the knob pickup block.
package kps_pkg;

    // Default geometry
    localparam int NUM_UNITS_DEF       = 16;
    localparam int NUM_CONTROLLERS_DEF = 128;
    localparam int FIRST_KNOB_DEF      = 6;

    // Operation codes
    localparam logic [1:0] OP_KNOB  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_CFG   = 2'd3;

    // Action codes
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_PICKUP = 2'd1;
    localparam logic [1:0] ACT_UP     = 2'd2;
    localparam logic [1:0] ACT_DOWN   = 2'd3;

    // Indicator codes
    localparam logic [1:0] IND_UP     = 2'd0;
    localparam logic [1:0] IND_DOWN   = 2'd1;
    localparam logic [1:0] IND_PICKED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_JITTER = 2'd0;
    localparam logic [1:0] CFG_PICKUP = 2'd1;
    localparam logic [1:0] CFG_CENTER = 2'd2;

    localparam logic [9:0] JITTER_RST = 10'd30;
    localparam logic [9:0] PICKUP_RST = 10'd30;
    localparam logic [8:0] CENTER_RST = 9'd50;

    // Scaling constants (thousandths)
    localparam int SCALE   = 1000;
    localparam int RAW_DIV = 511;
    localparam int HALF    = 500;
    localparam int MAX_V   = 1000;

    // ceil(2^33/511): exact floor division by 511 for any 24-bit dividend
    localparam logic [24:0] RECIP_511 = 25'd16810049;
    localparam int          RECIP_SH  = 33;

    // Divider geometry
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 18;

    // Knob value mapping modes
    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_HI    = 3'd1;
    localparam logic [2:0] MODE_LO    = 3'd2;
    localparam logic [2:0] MODE_SAT   = 3'd3;
    localparam logic [2:0] MODE_MID   = 3'd4;

    typedef struct packed {
        logic        assigned;
        logic        centered;
        logic        last_valid;
        logic [14:0] last_value;
    } t_ctl_word;

    typedef struct packed {
        logic [9:0] value;
        logic       loaded;
        logic       locked;
    } t_par_word;

    typedef struct packed {
        logic capture;
        logic sweep_ctl_we;
        logic sweep_par_we;
        logic calc;
        logic setup;
        logic post1;
        logic post2;
        logic cfg_wr;
        logic load_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       knob_ok;
        logic       load_ok;
        logic       cfg_ok;
        logic       sweep_last;
        logic       need_div;
        logic       div_busy;
        logic       out_free;
    } t_sts;

endpackage

[rtl/kps_ram.sv]
// Generic single-port RAM with registered read.
module kps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/kps_div.sv]
// Restoring divider, one quotient bit per cycle.
module kps_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   w_rem_sh;
    logic             w_fit;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient bits shift in where numerator bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;
endmodule

[rtl/kps_dp.sv]
// Datapath: controller and parameter tables, knob scaling, pickup decision and result register.
module kps_dp #(
    parameter int NUM_UNITS       = 16,
    parameter int NUM_CONTROLLERS = 128,
    parameter int FIRST_KNOB      = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kps_pkg::t_cmd i_cmd,
    output kps_pkg::t_sts o_sts,
    input  logic [1:0]    i_op,
    input  logic          i_is_control_change,
    input  logic [7:0]    i_message_length,
    input  logic [7:0]    i_status_byte,
    input  logic [6:0]    i_controller,
    input  logic [6:0]    i_data_lsb,
    input  logic [6:0]    i_data_msb,
    input  logic [9:0]    i_loaded_value,
    input  logic          i_set_assigned,
    input  logic          i_set_centered,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [9:0]    i_cfg_data,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [1:0]    o_action,
    output logic          o_send_message,
    output logic [1:0]    o_indicator_code
);
    import kps_pkg::*;

    localparam int DEPTH  = NUM_UNITS * NUM_CONTROLLERS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration registers
    logic [9:0] r_jitter;
    logic [9:0] r_pickup;
    logic [8:0] r_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jitter <= JITTER_RST;
            r_pickup <= PICKUP_RST;
            r_center <= CENTER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_JITTER: r_jitter <= i_cfg_data;
                CFG_PICKUP: r_pickup <= i_cfg_data;
                CFG_CENTER: r_center <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Captured beat
    logic [1:0]        r_op;
    logic              r_knob_pre;
    logic              r_in_table;
    logic [ADDR_W-1:0] r_idx;
    logic [13:0]       r_raw;
    logic [9:0]        r_loaded_value;
    logic              r_set_assigned;
    logic              r_set_centered;
    logic [10:0]       w_idx_full;

    assign w_idx_full = 11'(i_status_byte[3:0]) * 11'(NUM_CONTROLLERS) + 11'(i_controller);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op           <= i_op;
            r_knob_pre     <= i_is_control_change && (i_message_length >= 8'd4)
                              && (i_controller >= 7'(FIRST_KNOB));
            r_in_table     <= ({1'b0, i_status_byte[3:0]} < 5'(NUM_UNITS))
                              && ({1'b0, i_controller} < 8'(NUM_CONTROLLERS));
            r_idx          <= w_idx_full[ADDR_W-1:0];
            r_raw          <= {i_data_msb, i_data_lsb};
            r_loaded_value <= i_loaded_value;
            r_set_assigned <= i_set_assigned;
            r_set_centered <= i_set_centered;
        end
    end

    // Sweep counter for power-up and clear-all passes
    logic [ADDR_W-1:0] r_cnt;
    logic              w_sweep;

    assign w_sweep = i_cmd.sweep_ctl_we || i_cmd.sweep_par_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.capture) begin
            r_cnt <= '0;
        end else if (w_sweep) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Tables
    logic [ADDR_W-1:0] w_addr;
    t_ctl_word         w_ctl_rd;
    t_ctl_word         w_ctl_wd;
    t_par_word         w_par_rd;
    t_par_word         w_par_wd;
    logic              w_ctl_we;
    logic              w_par_we;

    assign w_addr = w_sweep ? r_cnt : r_idx;

    kps_ram #(.WIDTH($bits(t_ctl_word)), .DEPTH(DEPTH)) u_ctl_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctl_we),
        .i_addr  (w_addr),
        .i_wdata (w_ctl_wd),
        .o_rdata (w_ctl_rd)
    );

    kps_ram #(.WIDTH($bits(t_par_word)), .DEPTH(DEPTH)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_addr  (w_addr),
        .i_wdata (w_par_wd),
        .o_rdata (w_par_rd)
    );

    // Scaling setup
    logic [23:0] r_scaled;
    logic [19:0] r_thr_hi;
    logic [17:0] r_den_c;
    logic        r_cm_wide;
    logic        r_centered;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_scaled   <= 24'(r_raw) * 24'(SCALE);
            r_thr_hi   <= (20'(HALF) + 20'(r_center)) * 20'(RAW_DIV);
            r_den_c    <= (18'(HALF) - 18'(r_center)) * 18'(RAW_DIV);
            r_cm_wide  <= (r_center >= 9'(HALF));
            r_centered <= w_ctl_rd.centered;
        end
    end

    logic [2:0]           w_mode;
    logic [2:0]           r_mode;
    logic [23:0]          w_mul_in;
    logic [DIV_NUM_W-1:0] w_mul_out;
    logic [DIV_NUM_W-1:0] w_num;
    logic [DIV_DEN_W-1:0] w_den;
    logic                 w_need_div;

    always_comb begin
        if (!r_centered) begin
            w_mode = MODE_PLAIN;
        end else if (r_scaled > 24'(r_thr_hi)) begin
            w_mode = r_cm_wide ? MODE_SAT : MODE_HI;
        end else if (!r_cm_wide && (r_scaled < 24'(r_den_c))) begin
            w_mode = MODE_LO;
        end else begin
            w_mode = MODE_MID;
        end
    end

    // only the sloped sides of a centered knob need the divider
    assign w_mul_in   = (w_mode == MODE_HI) ? r_scaled - 24'(r_thr_hi) : r_scaled;
    assign w_mul_out  = DIV_NUM_W'(w_mul_in) * DIV_NUM_W'(HALF);
    assign w_num      = w_mul_out;
    assign w_den      = r_den_c;
    assign w_need_div = (w_mode == MODE_HI) || (w_mode == MODE_LO);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_mode <= w_mode;
        end
    end

    logic                 w_div_busy;
    logic [DIV_NUM_W-1:0] w_quot;

    kps_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.setup && w_need_div),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Knob value in thousandths, clipped per side
    logic [14:0] w_v;
    logic [14:0] r_v;
    logic        w_q_big;
    logic [48:0] w_plain_prod;
    logic [14:0] w_plain_v;

    assign w_q_big = (w_quot > DIV_NUM_W'(HALF));

    // plain knob: scaled/511 by reciprocal multiply, at most 32060
    assign w_plain_prod = 49'(r_scaled) * 49'(RECIP_511);
    assign w_plain_v    = w_plain_prod[RECIP_SH +: 15];

    always_comb begin
        case (r_mode)
            MODE_PLAIN: w_v = w_plain_v;
            MODE_HI:    w_v = w_q_big ? 15'(MAX_V) : w_quot[14:0] + 15'(HALF);
            MODE_LO:    w_v = w_q_big ? 15'(HALF) : w_quot[14:0];
            MODE_SAT:   w_v = 15'(MAX_V);
            default:    w_v = 15'(HALF);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post1) begin
            r_v <= w_v;
        end
    end

    // Jitter filter and pickup decision
    logic [14:0] w_jd;
    logic        w_drop;
    logic [14:0] w_p;
    logic [14:0] w_pd;
    logic [1:0]  w_act;
    logic [1:0]  w_code;

    assign w_jd   = (w_ctl_rd.last_value > r_v) ? w_ctl_rd.last_value - r_v
                                                : r_v - w_ctl_rd.last_value;
    assign w_drop = w_ctl_rd.last_valid && (w_jd < 15'(r_jitter));
    assign w_p    = 15'(w_par_rd.value);
    assign w_pd   = (r_v > w_p) ? r_v - w_p : w_p - r_v;

    always_comb begin
        if (w_par_rd.locked || !w_par_rd.loaded) begin
            w_act = ACT_PICKUP;
        end else if (w_pd > 15'(r_pickup)) begin
            w_act = (r_v > w_p) ? ACT_DOWN : ACT_UP;
        end else begin
            w_act = ACT_PICKUP;
        end
        case (w_act)
            ACT_UP:   w_code = IND_UP;
            ACT_DOWN: w_code = IND_DOWN;
            default:  w_code = IND_PICKED;
        endcase
    end

    // Table writes
    logic w_commit;

    assign w_commit = i_cmd.post2 && !w_drop;
    assign w_ctl_we = i_cmd.sweep_ctl_we || i_cmd.cfg_wr || w_commit;
    assign w_par_we = i_cmd.sweep_par_we || i_cmd.load_wr
                      || (w_commit && (w_act == ACT_PICKUP));

    always_comb begin
        if (w_sweep) begin
            w_ctl_wd = '0;
        end else if (i_cmd.cfg_wr) begin
            w_ctl_wd = '{assigned: r_set_assigned, centered: r_set_centered,
                         last_valid: w_ctl_rd.last_valid, last_value: w_ctl_rd.last_value};
        end else begin
            w_ctl_wd = '{assigned: w_ctl_rd.assigned, centered: w_ctl_rd.centered,
                         last_valid: 1'b1, last_value: r_v};
        end
    end

    always_comb begin
        if (w_sweep) begin
            w_par_wd = '0;
        end else if (i_cmd.load_wr) begin
            w_par_wd = '{value: r_loaded_value, loaded: 1'b1, locked: w_par_rd.locked};
        end else begin
            w_par_wd = '{value: w_par_rd.value, loaded: w_par_rd.loaded, locked: 1'b1};
        end
    end

    // Result of the current beat, then the output register
    logic [1:0] r_act;
    logic [1:0] r_code;
    logic       r_out_valid;
    logic [1:0] r_out_act;
    logic [1:0] r_out_code;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= ACT_NONE;
            r_code <= IND_UP;
        end else if (w_commit) begin
            r_act  <= w_act;
            r_code <= w_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_act  <= r_act;
            r_out_code <= r_code;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_action         = r_out_act;
    assign o_send_message   = (r_out_act != ACT_NONE);
    assign o_indicator_code = r_out_code;

    assign o_sts = '{
        op:         r_op,
        knob_ok:    r_knob_pre && r_in_table && w_ctl_rd.assigned,
        load_ok:    r_in_table && w_ctl_rd.assigned,
        cfg_ok:     r_in_table,
        sweep_last: (r_cnt == ADDR_W'(DEPTH - 1)),
        need_div:   w_need_div,
        div_busy:   w_div_busy,
        out_free:   !r_out_valid || !i_stall
    };
endmodule

[rtl/kps_ctrl.sv]
// Controller state machine sequencing table access, scaling and result hand-off.
module kps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  kps_pkg::t_sts i_sts,
    output kps_pkg::t_cmd o_cmd
);
    import kps_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_POST1 = 4'd6;
    localparam logic [3:0] S_POST2 = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_ctl_we = 1'b1;
                o_cmd.sweep_par_we = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                case (i_sts.op)
                    OP_KNOB: begin
                        if (i_sts.knob_ok) begin
                            o_cmd.calc = 1'b1;
                            n_state    = S_MUL;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    OP_LOAD: begin
                        o_cmd.load_wr = i_sts.load_ok;
                        n_state       = S_FIN;
                    end
                    OP_CLEAR: n_state = S_CLR;
                    default: begin
                        o_cmd.cfg_wr = i_sts.cfg_ok;
                        n_state      = S_FIN;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.need_div ? S_DIV : S_POST1;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_POST1;
                end
            end
            S_POST1: begin
                o_cmd.post1 = 1'b1;
                n_state     = S_POST2;
            end
            S_POST2: begin
                o_cmd.post2 = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.sweep_par_we = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_FIN;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

[rtl/knob_pickup_soft_takeover.sv]
// Knob pickup (soft takeover) top level: per unit and controller pickup tracking.
// Each accepted beat gives exactly one result beat. After reset the block clears
// its controller and parameter tables, all NUM_UNITS*NUM_CONTROLLERS entries
// (2048 at the defaults) at one entry per cycle, holding o_stall high;
// configuration writes are taken at any time. A knob message on a plain
// controller passes S_RD, S_CHK, S_MUL, S_POST1, S_POST2 and S_FIN, as does a
// centered one in the dead zone or at saturation; a centered one on a sloped
// side also waits in S_DIV on the 33-step restoring divider that rescales that
// side. Load, configure and ignored messages go from S_CHK to S_FIN. Clear all
// sweeps every parameter table entry in S_CLR. One beat is in flight at a time;
// a finished result waits in the output register while the next beat is accepted.
module knob_pickup_soft_takeover #(
    parameter int NUM_UNITS       = kps_pkg::NUM_UNITS_DEF,
    parameter int NUM_CONTROLLERS = kps_pkg::NUM_CONTROLLERS_DEF,
    parameter int FIRST_KNOB      = kps_pkg::FIRST_KNOB_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic       i_is_control_change,
    input  logic [7:0] i_message_length,
    input  logic [7:0] i_status_byte,
    input  logic [6:0] i_controller,
    input  logic [6:0] i_data_lsb,
    input  logic [6:0] i_data_msb,
    input  logic [9:0] i_loaded_value,
    input  logic       i_set_assigned,
    input  logic       i_set_centered,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_action,
    output logic       o_send_message,
    output logic [1:0] o_indicator_code,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);
    import kps_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    kps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    kps_dp #(
        .NUM_UNITS       (NUM_UNITS),
        .NUM_CONTROLLERS (NUM_CONTROLLERS),
        .FIRST_KNOB      (FIRST_KNOB)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_op                (i_op),
        .i_is_control_change (i_is_control_change),
        .i_message_length    (i_message_length),
        .i_status_byte       (i_status_byte),
        .i_controller        (i_controller),
        .i_data_lsb          (i_data_lsb),
        .i_data_msb          (i_data_msb),
        .i_loaded_value      (i_loaded_value),
        .i_set_assigned      (i_set_assigned),
        .i_set_centered      (i_set_centered),
        .i_cfg_valid         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_action            (o_action),
        .o_send_message      (o_send_message),
        .o_indicator_code    (o_indicator_code)
    );

    // one beat in flight: an accepted beat blocks the input next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a beat is in flight");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.setup && w_sts.need_div) |-> !w_sts.div_busy)
        else $error("divider restarted while busy");

    a_pickup_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_PICKUP)) |-> (o_indicator_code == IND_PICKED))
        else $error("pickup result without picked-up indicator");

    a_result_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");
endmodule

[tb/tb_knob_pickup_soft_takeover.sv]
`timescale 1ns / 100ps
// Self-checking testbench for knob_pickup_soft_takeover: directed table, random phases.
module tb_knob_pickup_soft_takeover;
    import kps_pkg::*;

    localparam int TABLE_DEPTH  = NUM_UNITS_DEF * NUM_CONTROLLERS_DEF;
    localparam int POOL_SIZE    = 6;
    localparam int PHASE_BEATS  = 122;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_GAP   = 8;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [1:0] op;
        logic       cc;
        logic [7:0] len;
        logic [7:0] status;
        logic [6:0] ctl;
        logic [6:0] lsb;
        logic [6:0] msb;
        logic [9:0] load;
        logic       asg;
        logic       ctr;
    } knob_beat_t;

    typedef struct packed {
        logic [1:0] action;
        logic       send;
        logic [1:0] code;
    } pickup_result_t;

    typedef struct packed {
        logic           fixed;
        pickup_result_t res;
        knob_beat_t     beat;
    } dir_row_t;

    localparam pickup_result_t QUIET_RES  = '0;
    localparam pickup_result_t PICKED_RES = '{ACT_PICKUP, 1'b1, IND_PICKED};

    // fixed=0 rows are checked against the predictor only
    // beat: op, cc, len, status, ctl, lsb, msb, load, assign, center
    localparam dir_row_t DIRECTED_TBL [25] = '{
        // unassigned knob
        '{1'b1, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CFG,   1'b0, 8'd0,   8'h90, 7'd10,  7'd0,   7'd0,   10'd0,
                              1'b1, 1'b0}},
        // max raw, nothing loaded
        '{1'b1, PICKED_RES, '{OP_KNOB,  1'b1, 8'd255, 8'h90, 7'd10,  7'd127, 7'd127, 10'd0,
                              1'b0, 1'b0}},
        // locked stays picked up
        '{1'b1, PICKED_RES, '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CLEAR, 1'b1, 8'd9,   8'h5A, 7'd33,  7'd1,   7'd2,   10'd3,
                              1'b1, 1'b1}},
        '{1'b1, QUIET_RES,  '{OP_LOAD,  1'b0, 8'd0,   8'h90, 7'd10,  7'd0,   7'd0,   10'd1000,
                              1'b0, 1'b0}},
        // same value as last sent: jitter drop
        '{1'b1, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        '{1'b0, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd100, 7'd0,   10'd0,
                              1'b0, 1'b0}},
        // not a control change
        '{1'b1, QUIET_RES,  '{OP_KNOB,  1'b0, 8'd200, 8'h90, 7'd10,  7'd127, 7'd127, 10'd0,
                              1'b0, 1'b0}},
        // short message
        '{1'b1, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd3,   8'h90, 7'd10,  7'd127, 7'd127, 10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CFG,   1'b0, 8'd0,   8'h90, 7'd5,   7'd0,   7'd0,   10'd0,
                              1'b1, 1'b0}},
        // button controller, assigned but ignored
        '{1'b1, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd5,   7'd127, 7'd127, 10'd0,
                              1'b0, 1'b0}},
        // raw 511 -> 1000, on the loaded value
        '{1'b1, PICKED_RES, '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd127, 7'd3,   10'd0,
                              1'b0, 1'b0}},
        '{1'b1, PICKED_RES, '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CLEAR, 1'b0, 8'd0,   8'hA5, 7'd0,   7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CFG,   1'b0, 8'd0,   8'hFF, 7'd127, 7'd0,   7'd0,   10'd0,
                              1'b1, 1'b1}},
        '{1'b1, QUIET_RES,  '{OP_LOAD,  1'b0, 8'd0,   8'hFF, 7'd127, 7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        // centered: clip high, dead zone, low end
        '{1'b0, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'hFF, 7'd127, 7'd127, 7'd127, 10'd0,
                              1'b0, 1'b0}},
        '{1'b0, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'hFF, 7'd127, 7'd127, 7'd1,   10'd0,
                              1'b0, 1'b0}},
        '{1'b0, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'hFF, 7'd127, 7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        // load to an unassigned controller is dropped
        '{1'b1, QUIET_RES,  '{OP_LOAD,  1'b0, 8'd0,   8'h22, 7'd20,  7'd0,   7'd0,   10'd500,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CFG,   1'b0, 8'd0,   8'h22, 7'd20,  7'd0,   7'd0,   10'd0,
                              1'b1, 1'b0}},
        '{1'b1, PICKED_RES, '{OP_KNOB,  1'b1, 8'd4,   8'h22, 7'd20,  7'd0,   7'd64,  10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_CFG,   1'b0, 8'd0,   8'h90, 7'd10,  7'd0,   7'd0,   10'd0,
                              1'b0, 1'b0}},
        '{1'b1, QUIET_RES,  '{OP_KNOB,  1'b1, 8'd4,   8'h90, 7'd10,  7'd127, 7'd127, 10'd0,
                              1'b0, 1'b0}}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_op;
    logic       i_is_control_change;
    logic [7:0] i_message_length;
    logic [7:0] i_status_byte;
    logic [6:0] i_controller;
    logic [6:0] i_data_lsb;
    logic [6:0] i_data_msb;
    logic [9:0] i_loaded_value;
    logic       i_set_assigned;
    logic       i_set_centered;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_action;
    logic       o_send_message;
    logic [1:0] o_indicator_code;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    knob_pickup_soft_takeover dut (.*);

    // predictor copy of the controller and parameter tables
    bit          ctl_asg  [TABLE_DEPTH];
    bit          ctl_ctr  [TABLE_DEPTH];
    bit          sent_ok  [TABLE_DEPTH];
    logic [14:0] sent_val [TABLE_DEPTH];
    logic [9:0]  par_val  [TABLE_DEPTH];
    bit          par_ld   [TABLE_DEPTH];
    bit          par_lock [TABLE_DEPTH];
    logic [9:0]  jitter_q;
    logic [9:0]  pickup_q;
    logic [8:0]  center_q;

    pickup_result_t expected_q [$];
    int             n_fail;
    int unsigned    beats_in;
    int unsigned    burst_left;
    logic [3:0]     pool_unit [POOL_SIZE];
    logic [6:0]     pool_ctl  [POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

    // raw 14-bit knob position to thousandths, exact then truncated once
    function automatic int unsigned knob_thou(input logic [13:0] raw, input bit centered);
        longint unsigned scaled, cm, hi_edge, lo_edge, v;
        scaled  = raw;
        scaled  = scaled * SCALE;
        cm      = center_q;
        hi_edge = (HALF + cm) * RAW_DIV;
        lo_edge = (cm < HALF) ? (HALF - cm) * RAW_DIV : 0;
        if (!centered)
            return int'(scaled / RAW_DIV);
        if (scaled > hi_edge) begin
            if (cm >= HALF)
                return MAX_V;
            v = (scaled - hi_edge) * HALF / lo_edge + HALF;
            return (v > MAX_V) ? MAX_V : int'(v);
        end
        if (cm < HALF && scaled < lo_edge) begin
            v = scaled * HALF / lo_edge;
            return (v > HALF) ? HALF : int'(v);
        end
        return HALF;
    endfunction

    function automatic pickup_result_t predict_pickup(input knob_beat_t b);
        pickup_result_t r;
        logic [10:0]    idx;
        int unsigned    v, last, p, delta;
        int             n;
        r   = QUIET_RES;
        idx = {b.status[3:0], b.ctl};
        case (b.op)
            OP_KNOB: begin
                if (b.cc && b.len >= 4 && b.ctl >= FIRST_KNOB_DEF && ctl_asg[idx]) begin
                    v     = knob_thou({b.msb, b.lsb}, ctl_ctr[idx]);
                    last  = sent_val[idx];
                    delta = (last > v) ? last - v : v - last;
                    if (!sent_ok[idx] || delta >= jitter_q) begin
                        sent_ok[idx]  = 1'b1;
                        sent_val[idx] = v[14:0];
                        p     = par_val[idx];
                        delta = (v > p) ? v - p : p - v;
                        if (par_lock[idx] || !par_ld[idx] || delta <= pickup_q) begin
                            r = PICKED_RES;
                            par_lock[idx] = 1'b1;
                        end else if (v > p) begin
                            r = '{ACT_DOWN, 1'b1, IND_DOWN};
                        end else begin
                            r = '{ACT_UP, 1'b1, IND_UP};
                        end
                    end
                end
            end
            OP_LOAD: begin
                if (ctl_asg[idx]) begin
                    par_val[idx] = b.load;
                    par_ld[idx]  = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (n = 0; n < TABLE_DEPTH; n++) begin
                    par_val[n]  = '0;
                    par_ld[n]   = 1'b0;
                    par_lock[n] = 1'b0;
                end
            end
            default: begin
                ctl_asg[idx] = b.asg;
                ctl_ctr[idx] = b.ctr;
            end
        endcase
        return r;
    endfunction

    // mostly well-formed traffic to a small set of controllers, some noise
    function automatic knob_beat_t random_beat();
        knob_beat_t  b;
        int unsigned slot, pick;
        int          near;
        logic [13:0] raw;
        slot     = $urandom_range(POOL_SIZE - 1);
        pick     = $urandom_range(999);
        b.status = 8'($urandom_range(255));
        b.status[3:0] = pool_unit[slot];
        b.ctl    = pool_ctl[slot];
        if ($urandom_range(11) == 0) begin
            b.status = 8'($urandom_range(255));
            b.ctl    = 7'($urandom_range(127));
        end
        b.cc   = 1'b1;
        b.len  = 8'($urandom_range(255, 4));
        b.load = 10'($urandom_range(1000));
        b.asg  = ($urandom_range(9) != 0);
        b.ctr  = 1'($urandom_range(1));
        raw    = 14'($urandom_range(16383));
        if (pick < 10) begin
            b.op = OP_CLEAR;
            b.cc = 1'($urandom_range(1));
        end else if (pick < 110) begin
            b.op = OP_CFG;
        end else if (pick < 260) begin
            b.op = OP_LOAD;
        end else begin
            b.op = OP_KNOB;
            case ($urandom_range(9))
                0, 1, 2: ;
                3, 4, 5, 6: raw = 14'($urandom_range(520));
                default: begin
                    near = int'(par_val[{b.status[3:0], b.ctl}]) * RAW_DIV / SCALE
                           + int'($urandom_range(30)) - 15;
                    raw  = (near < 0) ? '0 : 14'(near);
                end
            endcase
            if (pick >= 880) begin
                case ($urandom_range(3))
                    0: b.cc  = 1'b0;
                    1: b.len = 8'($urandom_range(3));
                    2: b.ctl = 7'($urandom_range(FIRST_KNOB_DEF - 1));
                    default: begin
                        b.status = 8'($urandom_range(255));
                        b.ctl    = 7'($urandom_range(127));
                    end
                endcase
            end
        end
        b.msb = raw[13:7];
        b.lsb = raw[6:0];
        return b;
    endfunction

    task automatic send_beat(input knob_beat_t b, input bit fixed,
                             input pickup_result_t fixed_res);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(3) == 0)
                gap = 0;
            else if ($urandom_range(7) == 0)
                gap = $urandom_range(20, 5);
            else
                gap = $urandom_range(3, 1);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_op                <= b.op;
        i_is_control_change <= b.cc;
        i_message_length    <= b.len;
        i_status_byte       <= b.status;
        i_controller        <= b.ctl;
        i_data_lsb          <= b.lsb;
        i_data_msb          <= b.msb;
        i_loaded_value      <= b.load;
        i_set_assigned      <= b.asg;
        i_set_centered      <= b.ctr;
        i_valid             <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        beats_in++;
        if (fixed) begin
            void'(predict_pickup(b));
            expected_q.push_back(fixed_res);
        end else begin
            expected_q.push_back(predict_pickup(b));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_JITTER: jitter_q = val;
            CFG_PICKUP: pickup_q = val;
            CFG_CENTER: center_q = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering beats and let every expected result drain out
    task automatic settle(input int unsigned extra);
        @(negedge i_clk);
        i_valid    <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin : result_stall
        int unsigned run_left, pct;
        bit          held;
        i_stall  = 1'b0;
        run_left = 0;
        pct      = 0;
        held     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && beats_in >= HOLD_AT) begin
                // long back-pressure so the block fills and stalls its input
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(48, 1);
                    case ($urandom_range(4))
                        0, 1: pct = 0;
                        2: pct = 30;
                        3: pct = 60;
                        default: pct = 90;
                    endcase
                end
                run_left--;
                i_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    initial begin : result_check
        pickup_result_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: action %0d code %0d",
                           o_action, o_indicator_code);
                    n_fail++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_action !== want.action) begin
                        $error("action: expected %0d, actual %0d", want.action, o_action);
                        n_fail++;
                    end
                    if (o_send_message !== want.send) begin
                        $error("send_message: expected %0d, actual %0d",
                               want.send, o_send_message);
                        n_fail++;
                    end
                    if (o_indicator_code !== want.code) begin
                        $error("indicator_code: expected %0d, actual %0d",
                               want.code, o_indicator_code);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [9:0] cfg_j, cfg_p;
        logic [8:0] cfg_c;
        int         n;
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_op                = OP_KNOB;
        i_is_control_change = 1'b0;
        i_message_length    = '0;
        i_status_byte       = '0;
        i_controller        = '0;
        i_data_lsb          = '0;
        i_data_msb          = '0;
        i_loaded_value      = '0;
        i_set_assigned      = 1'b0;
        i_set_centered      = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = CFG_JITTER;
        i_cfg_data          = '0;
        n_fail     = 0;
        beats_in   = 0;
        burst_left = 0;
        jitter_q   = JITTER_RST;
        pickup_q   = PICKUP_RST;
        center_q   = CENTER_RST;
        for (n = 0; n < TABLE_DEPTH; n++) begin
            ctl_asg[n]  = 1'b0;
            ctl_ctr[n]  = 1'b0;
            sent_ok[n]  = 1'b0;
            sent_val[n] = '0;
            par_val[n]  = '0;
            par_ld[n]   = 1'b0;
            par_lock[n] = 1'b0;
        end
        for (n = 0; n < POOL_SIZE; n++) begin
            pool_unit[n] = 4'($urandom_range(15));
            pool_ctl[n]  = 7'($urandom_range(127, FIRST_KNOB_DEF));
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_TBL[k])
            send_beat(DIRECTED_TBL[k].beat, DIRECTED_TBL[k].fixed, DIRECTED_TBL[k].res);

        for (n = 0; n < NUM_PHASES; n++) begin
            settle(SETTLE_GAP);
            case (n)
                0: begin
                    cfg_j = '0;
                    cfg_p = '0;
                    cfg_c = '0;
                end
                1: begin
                    cfg_j = 10'd1000;
                    cfg_p = 10'd1000;
                    cfg_c = 9'd500;
                end
                2: begin
                    cfg_j = 10'd5;
                    cfg_p = 10'd60;
                    cfg_c = 9'd499;
                end
                default: begin
                    cfg_j = ($urandom_range(3) == 0) ? 10'($urandom_range(1000))
                                                     : 10'($urandom_range(60));
                    cfg_p = 10'($urandom_range(1000));
                    cfg_c = 9'($urandom_range(500));
                end
            endcase
            write_reg(CFG_JITTER, cfg_j);
            write_reg(CFG_PICKUP, cfg_p);
            write_reg(CFG_CENTER, {1'b0, cfg_c});
            repeat (PHASE_BEATS) send_beat(random_beat(), 1'b0, QUIET_RES);
        end

        settle(DRAIN_CYCLES);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
